@@ rtl/jfdd_pkg.sv @@
package jfdd_pkg;

    // Link framing bytes
    localparam logic [7:0] STX_BYTE = 8'h02;
    localparam logic [7:0] ETX_BYTE = 8'h03;

    // Frame payload store
    localparam int FRAME_LEN = 6;
    localparam int POS_W     = 3;
    localparam int IDX_W     = 3;

    localparam logic [POS_W-1:0] POS_HUNT    = 3'd0;
    localparam logic [POS_W-1:0] POS_BTN_END = 3'd2;
    localparam logic [POS_W-1:0] POS_LAST    = 3'd7;

    // Result kinds
    localparam logic KIND_MOTOR  = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    // Button letters, set and clear pairs
    localparam logic [6:0] KEY_A = 7'h41;
    localparam logic [6:0] KEY_B = 7'h42;
    localparam logic [6:0] KEY_C = 7'h43;
    localparam logic [6:0] KEY_D = 7'h44;
    localparam logic [6:0] KEY_E = 7'h45;
    localparam logic [6:0] KEY_F = 7'h46;
    localparam logic [6:0] KEY_G = 7'h47;
    localparam logic [6:0] KEY_H = 7'h48;
    localparam logic [6:0] KEY_K = 7'h4B;
    localparam logic [6:0] KEY_L = 7'h4C;

    // Axis arithmetic: the three ASCII digits carry a bias of 48*111, and the
    // axis value is offset by a further 100.
    localparam logic [13:0] DIGIT_BIAS = 14'd5428;
    localparam logic [7:0]  AXIS_SAT   = 8'd200;
    // floor(n*32/25) for n < 200 as (n*5243) >> 12
    localparam logic [12:0] RECIP       = 13'd5243;
    localparam int          RECIP_SHIFT = 12;
    localparam logic [8:0]  CENTRE      = 9'd128;
    localparam logic [7:0]  DUTY_MAX    = 8'd255;

    typedef struct packed {
        logic                           kind;
        logic [FRAME_LEN-1:0][6:0]      payload;
        logic [5:0]                     buttons;
    } token_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] x_pre;
        logic [7:0] y_pre;
        logic [5:0] buttons;
    } axis_t;

    function automatic logic [5:0] btn_update(input logic [5:0] btn, input logic [6:0] letter);
        logic [5:0] r;
        r = btn;
        case (letter)
            KEY_A:   r[0] = 1'b1;
            KEY_B:   r[0] = 1'b0;
            KEY_C:   r[1] = 1'b1;
            KEY_D:   r[1] = 1'b0;
            KEY_E:   r[2] = 1'b1;
            KEY_F:   r[2] = 1'b0;
            KEY_G:   r[3] = 1'b1;
            KEY_H:   r[3] = 1'b0;
            KEY_K:   r[5] = 1'b1;
            KEY_L:   r[5] = 1'b0;
            default: r = btn;
        endcase
        return r;
    endfunction

    // Axis value before scaling, limited to 0..200; 200 stands for saturation.
    function automatic logic [7:0] axis_pre(input logic [6:0] d0, input logic [6:0] d1,
                                            input logic [6:0] d2);
        logic [13:0] sum;
        logic [13:0] diff;
        logic [7:0]  r;
        sum  = 14'(d0) * 14'd100 + 14'(d1) * 14'd10 + 14'(d2);
        diff = sum - DIGIT_BIAS;
        if (sum <= DIGIT_BIAS) begin
            r = 8'd0;
        end else if (diff >= 14'(AXIS_SAT)) begin
            r = AXIS_SAT;
        end else begin
            r = diff[7:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/joystick_frame_to_differential_drive_top.sv @@
// Joystick link parser and differential-drive mixer. One received link byte is
// taken per beat on the s_ channel, and a new byte can be accepted on every
// clock cycle. The s_ channel stalls only when all three stages already hold a
// result and the m_ channel is not taking its beat, so up to three results can
// queue behind a slow receiver. A frame STX, letter, ETX updates the six button
// bits and yields a button beat (m_tuser high, motor fields zero). A frame STX,
// six ASCII digits, ETX yields a motor beat (m_tuser low) with the phase levels
// and PWM duties for both motors. All other bytes give no result. The frame
// parser registers the finished frame on the accepting edge, then the axis
// decoder registers both decoded axes, and then the scaling and mixing stage
// loads the output register and m_tvalid rises. The deadband register sits
// at byte address 0 of the APB port (reset value 10) and should only be written
// while no result is in flight.
module joystick_frame_to_differential_drive_top
    import jfdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] left_forward, [1] right_forward,
                                   // [9:2] left_duty, [17:10] right_duty,
                                   // [23:18] button_bits
    output logic        m_tuser    // [0] result_kind
);

    localparam logic REG_DEADBAND = 1'b0;

    logic       deadband_sel;
    logic [6:0] deadband_val_reg;
    logic       cfg_wr;
    logic       tok_valid, tok_ready;
    token_t     tok;
    logic       ax_valid, ax_ready;
    axis_t      ax;

    // The register is decoded on the word address; byte offsets are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign deadband_sel = (paddr[2] == REG_DEADBAND);
    assign prdata = deadband_sel ? {25'd0, deadband_val_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_val_reg <= 7'd10;
        end else if (cfg_wr && deadband_sel) begin
            deadband_val_reg <= pwdata[6:0];
        end
    end

    // Frame hunting, payload capture and button register.
    jfdd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    // Decimal decoding of both axes.
    jfdd_axis u_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .ax_valid  (ax_valid),
        .ax_ready  (ax_ready),
        .ax        (ax)
    );

    // Scaling, deadband, mixing and the output register.
    jfdd_mixer u_mixer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .deadband (deadband_val_reg),
        .ax_valid (ax_valid),
        .ax_ready (ax_ready),
        .ax       (ax),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    // A button beat never carries motor drive.
    a_button_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_BUTTON) |-> m_tdata[17:0] == 18'd0)
        else $error("button beat carries motor fields");

    // With the output register empty the pipeline must accept a byte.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A deadband write lands in the register.
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr && (paddr[2] == REG_DEADBAND) |=> deadband_val_reg == $past(pwdata[6:0]))
        else $error("deadband write lost");
`endif

endmodule

@@ rtl/jfdd_parser.sv @@
module jfdd_parser
    import jfdd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   in_byte,
    output logic         tok_valid,
    input  logic         tok_ready,
    output token_t       tok
);

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [FRAME_LEN-1:0][6:0] payload_reg, payload_next;
    logic [5:0]                btn_reg, btn_next;
    logic                      tok_vld_reg, tok_vld_next;
    token_t                    tok_reg, tok_next;
    logic                      fire;
    logic                      emit;
    logic                      emit_kind;
    logic [IDX_W-1:0]          wr_idx;

    assign in_ready  = !tok_vld_reg || tok_ready;
    assign fire      = in_valid && in_ready;
    assign wr_idx    = pos_reg - 3'd1;
    assign tok_valid = tok_vld_reg;
    assign tok       = tok_reg;

    always_comb begin
        pos_next     = pos_reg;
        payload_next = payload_reg;
        btn_next     = btn_reg;
        emit         = 1'b0;
        emit_kind    = KIND_MOTOR;
        if (fire) begin
            if (pos_reg == POS_HUNT) begin
                pos_next = (in_byte == STX_BYTE) ? 3'd1 : POS_HUNT;
            end else if (in_byte[7]) begin
                pos_next = POS_HUNT;
            end else if (in_byte == ETX_BYTE && pos_reg == POS_BTN_END) begin
                pos_next  = POS_HUNT;
                btn_next  = btn_update(btn_reg, payload_reg[0]);
                emit      = 1'b1;
                emit_kind = KIND_BUTTON;
            end else if (in_byte == ETX_BYTE && pos_reg == POS_LAST) begin
                pos_next  = POS_HUNT;
                emit      = 1'b1;
                emit_kind = KIND_MOTOR;
            end else if (pos_reg == POS_LAST) begin
                pos_next = POS_HUNT;
            end else begin
                payload_next[wr_idx] = in_byte[6:0];
                pos_next             = pos_reg + 3'd1;
            end
        end
    end

    always_comb begin
        tok_next.kind    = emit_kind;
        tok_next.payload = payload_reg;
        tok_next.buttons = btn_next;
        if (fire) begin
            tok_vld_next = emit;
        end else if (tok_ready) begin
            tok_vld_next = 1'b0;
        end else begin
            tok_vld_next = tok_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HUNT;
            btn_reg     <= 6'd0;
            tok_vld_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            btn_reg     <= btn_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        payload_reg <= payload_next;
        if (fire && emit) begin
            tok_reg <= tok_next;
        end
    end

endmodule

@@ rtl/jfdd_axis.sv @@
module jfdd_axis
    import jfdd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   tok_valid,
    output logic   tok_ready,
    input  token_t tok,
    output logic   ax_valid,
    input  logic   ax_ready,
    output axis_t  ax
);

    logic  ax_vld_reg;
    axis_t ax_reg, ax_next;

    assign tok_ready = !ax_vld_reg || ax_ready;
    assign ax_valid  = ax_vld_reg;
    assign ax        = ax_reg;

    always_comb begin
        ax_next.kind    = tok.kind;
        ax_next.x_pre   = axis_pre(tok.payload[0], tok.payload[1], tok.payload[2]);
        ax_next.y_pre   = axis_pre(tok.payload[3], tok.payload[4], tok.payload[5]);
        ax_next.buttons = tok.buttons;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_vld_reg <= 1'b0;
        end else if (tok_ready) begin
            ax_vld_reg <= tok_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_ready && tok_valid) begin
            ax_reg <= ax_next;
        end
    end

endmodule

@@ rtl/jfdd_mixer.sv @@
module jfdd_mixer
    import jfdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [6:0]  deadband,
    input  logic        ax_valid,
    output logic        ax_ready,
    input  axis_t       ax,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tuser
);

    logic        out_vld_reg;
    logic [23:0] data_reg, data_next;
    logic        kind_reg;
    logic [7:0]  x_val, y_val;
    logic [7:0]  xm, ym;
    logic        fwd, rgt, neg;
    logic [8:0]  diff, dmag, sum;
    logic [7:0]  duty_d, duty_s;
    logic        lf, rf;
    logic [7:0]  ld, rd;

    function automatic logic [7:0] scale(input logic [7:0] pre);
        logic [20:0] prod;
        logic [7:0]  r;
        prod = 21'(pre) * 21'(RECIP);
        if (pre >= AXIS_SAT) begin
            r = DUTY_MAX;
        end else begin
            r = prod[RECIP_SHIFT +: 8];
        end
        return r;
    endfunction

    function automatic logic [7:0] snap(input logic [7:0] v, input logic [6:0] db);
        logic [8:0] lo, hi;
        lo = {1'b0, v} + {2'b0, db};
        hi = CENTRE + {2'b0, db};
        return (lo > CENTRE && {1'b0, v} < hi) ? CENTRE[7:0] : v;
    endfunction

    // Twice the magnitude, clamped to full duty.
    function automatic logic [7:0] duty(input logic [8:0] mag);
        return (mag >= CENTRE) ? DUTY_MAX : {mag[6:0], 1'b0};
    endfunction

    assign ax_ready = !out_vld_reg || m_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

    always_comb begin
        x_val  = snap(scale(ax.x_pre), deadband);
        y_val  = snap(scale(ax.y_pre), deadband);
        fwd    = !({1'b0, x_val} > CENTRE);
        rgt    = {1'b0, y_val} > CENTRE;
        xm     = fwd ? (CENTRE[7:0] - x_val) : (x_val - CENTRE[7:0]);
        ym     = rgt ? (y_val - CENTRE[7:0]) : (CENTRE[7:0] - y_val);
        diff   = {1'b0, xm} - {1'b0, ym};
        neg    = diff[8];
        dmag   = neg ? (9'd0 - diff) : diff;
        sum    = {1'b0, xm} + {1'b0, ym};
        duty_d = duty(dmag);
        duty_s = duty(sum);
        if (rgt) begin
            ld = duty_s;
            lf = fwd;
            rd = duty_d;
            rf = fwd && !neg;
        end else begin
            ld = duty_d;
            lf = fwd && !neg;
            rd = duty_s;
            rf = fwd;
        end
        if (ax.kind == KIND_BUTTON) begin
            data_next = {ax.buttons, 18'd0};
        end else begin
            data_next = {ax.buttons, rd, ld, rf, lf};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (ax_ready) begin
            out_vld_reg <= ax_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ax_ready && ax_valid) begin
            data_reg <= data_next;
            kind_reg <= ax.kind;
        end
    end

endmodule

@@ bench/tb_joystick_frame_to_differential_drive_top.sv @@
`timescale 1ns / 1ps

// Bench for the joystick link parser and differential-drive mixer.
//
// Link bytes wait in a queue that the stimulus process fills. A clocked driver
// offers them on the s_ channel, and a clocked monitor follows both channels.
// Each byte that the block accepts is fed through a predictor of the frame
// parser, the button register and the axis mixer. Every result that the
// predictor produces joins a queue. Each m_ beat is then checked, field by
// field, against the oldest entry in that queue.
module tb_joystick_frame_to_differential_drive_top;
    import jfdd_pkg::*;

    localparam logic [2:0] DEADBAND_ADDR  = 3'd0;
    localparam int         DEADBAND_RESET = 10;
    localparam int         PHASE_ITEMS    = 390;
    localparam int         DIRECTED_ITEMS = 28;
    localparam int         NUM_PHASES     = 5;
    // The settle time covers the path from an ETX beat through the parser,
    // axis and mixer registers to its result, with margin on top.
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         STALL_LIMIT    = 2000;

    typedef struct packed {
        logic       kind;
        logic       left_fwd;
        logic       right_fwd;
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic [5:0] buttons;
    } drive_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [0] left_forward, [1] right_forward,
                                  // [9:2] left_duty, [17:10] right_duty,
                                  // [23:18] button_bits
    logic        m_tuser;         // [0] result_kind

    // Bytes still to be offered, and the results that the block still owes.
    logic [7:0]    link_bytes [$];
    drive_result_t expected_drive [$];

    // The predictor's own copy of the block's state and its one register.
    int          deadband_setting;
    logic [2:0]  frame_pos;
    logic [6:0]  payload [6];
    logic [5:0]  buttons;

    // Idle rates as percentages, set per phase by the stimulus process.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    int unsigned errors        = 0;
    int unsigned bytes_taken   = 0;
    int unsigned motor_beats   = 0;
    int unsigned button_beats  = 0;
    int unsigned quiet_cycles  = 0;
    int          db_history [NUM_PHASES];

    joystick_frame_to_differential_drive_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Each letter either sets or clears one button. Bit four has no letter at
    // all, so it can never change.
    function automatic logic [5:0] apply_key(input logic [5:0] cur, input logic [6:0] key);
        logic [5:0] set_mask;
        logic [5:0] clr_mask;
        set_mask = '0;
        clr_mask = '0;
        case (key)
            KEY_A: set_mask = 6'b000001;
            KEY_B: clr_mask = 6'b000001;
            KEY_C: set_mask = 6'b000010;
            KEY_D: clr_mask = 6'b000010;
            KEY_E: set_mask = 6'b000100;
            KEY_F: clr_mask = 6'b000100;
            KEY_G: set_mask = 6'b001000;
            KEY_H: clr_mask = 6'b001000;
            KEY_K: set_mask = 6'b100000;
            KEY_L: clr_mask = 6'b100000;
            default: ;
        endcase
        return (cur | set_mask) & ~clr_mask;
    endfunction

    // Three ASCII characters form a decimal number with an offset of 100, and
    // that number is scaled by 256/200. Characters that are not digits simply
    // count as their code minus 48. The result saturates at eight bits, as the
    // block does.
    function automatic int scale_axis(input logic [6:0] hi, input logic [6:0] mid,
                                      input logic [6:0] lo);
        int v;
        v = (int'(hi) - 48) * 100 + (int'(mid) - 48) * 10 + (int'(lo) - 48) - 100;
        if (v <= 0)
            return 0;
        v = (v * 256) / 200;
        return (v > 255) ? 255 : v;
    endfunction

    // Values strictly inside the deadband either side of centre snap to 128.
    function automatic int snap_centre(input int v);
        if (v > 128 - deadband_setting && v < 128 + deadband_setting)
            return 128;
        return v;
    endfunction

    function automatic drive_result_t mix_axes();
        drive_result_t r;
        int            x;
        int            y;
        int            sl;
        int            sr;
        logic          fwd;
        logic          steer_right;
        x = snap_centre(scale_axis(payload[0], payload[1], payload[2]));
        y = snap_centre(scale_axis(payload[3], payload[4], payload[5]));
        // X above centre means reverse, and Y above centre means steer right.
        // Both axes are then folded to magnitudes from the centre.
        if (x > 128) begin
            fwd = 1'b0;
            x   = x - 128;
        end else begin
            fwd = 1'b1;
            x   = 128 - x;
        end
        if (y > 128) begin
            steer_right = 1'b1;
            y           = y - 128;
        end else begin
            steer_right = 1'b0;
            y           = 128 - y;
        end
        if (steer_right) begin
            sl = 2 * x + 2 * y;
            sr = 2 * x - 2 * y;
        end else begin
            sl = 2 * x - 2 * y;
            sr = 2 * x + 2 * y;
        end
        r.kind      = KIND_MOTOR;
        r.left_fwd  = fwd;
        r.right_fwd = fwd;
        // A negative side drives with its phase low and its magnitude taken.
        if (sl < 0) begin
            r.left_fwd = 1'b0;
            sl         = -sl;
        end
        if (sr < 0) begin
            r.right_fwd = 1'b0;
            sr          = -sr;
        end
        r.left_duty  = (sl > 255) ? DUTY_MAX : 8'(sl);
        r.right_duty = (sr > 255) ? DUTY_MAX : 8'(sr);
        r.buttons    = buttons;
        return r;
    endfunction

    // One accepted link byte goes through the frame parser. A finished frame
    // leaves its expected result in the queue.
    task automatic parse_link_byte(input logic [7:0] b);
        drive_result_t r;
        if (frame_pos == POS_HUNT) begin
            // While hunting, every byte other than STX is dropped.
            frame_pos = (b == STX_BYTE) ? 3'd1 : POS_HUNT;
        end else if (b[7]) begin
            // A byte above 127 inside a frame abandons the frame.
            frame_pos = POS_HUNT;
        end else if (b == ETX_BYTE && frame_pos == POS_BTN_END) begin
            buttons      = apply_key(buttons, payload[0]);
            r            = '0;
            r.kind       = KIND_BUTTON;
            r.buttons    = buttons;
            expected_drive.push_back(r);
            frame_pos    = POS_HUNT;
        end else if (b == ETX_BYTE && frame_pos == POS_LAST) begin
            expected_drive.push_back(mix_axes());
            frame_pos = POS_HUNT;
        end else if (frame_pos == POS_LAST) begin
            // A seventh payload byte means the frame is too long. It is not
            // looked at as a possible STX.
            frame_pos = POS_HUNT;
        end else begin
            // An early ETX lands here as well and is kept as plain payload.
            payload[frame_pos - 3'd1] = b[6:0];
            frame_pos                 = frame_pos + 3'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_drive_result();
        drive_result_t got;
        drive_result_t want;
        got.kind       = m_tuser;
        got.left_fwd   = m_tdata[0];
        got.right_fwd  = m_tdata[1];
        got.left_duty  = m_tdata[9:2];
        got.right_duty = m_tdata[17:10];
        got.buttons    = m_tdata[23:18];
        if (expected_drive.size() == 0) begin
            flag_mismatch("result beat with none pending, kind", got.kind, -1);
            return;
        end
        want = expected_drive.pop_front();
        if (got.kind !== want.kind)
            flag_mismatch("result_kind", got.kind, want.kind);
        if (got.left_fwd !== want.left_fwd)
            flag_mismatch("left_forward", got.left_fwd, want.left_fwd);
        if (got.right_fwd !== want.right_fwd)
            flag_mismatch("right_forward", got.right_fwd, want.right_fwd);
        if (got.left_duty !== want.left_duty)
            flag_mismatch("left_duty", got.left_duty, want.left_duty);
        if (got.right_duty !== want.right_duty)
            flag_mismatch("right_duty", got.right_duty, want.right_duty);
        if (got.buttons !== want.buttons)
            flag_mismatch("button_bits", got.buttons, want.buttons);
        if (want.kind == KIND_BUTTON)
            button_beats++;
        else
            motor_beats++;
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // A new byte goes out only once the previous beat has been taken, so
    // tvalid never drops while a beat is on offer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= link_bytes.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // The result is checked before the byte taken on the same edge is
    // predicted. A result that appears on that edge always belongs to an
    // older frame, given the latency of the block.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_drive_result();
            if (s_tvalid && s_tready) begin
                parse_link_byte(s_tdata);
                bytes_taken++;
            end
        end
    end

    // Watchdog: the run ends here if neither channel moves a beat for too
    // long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // APB access
    // ------------------------------------------------------------------

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want)
            flag_mismatch("deadband read-back", prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // The block is idle once every byte has been taken and every result has
    // arrived. The extra cycles then cover any frame that is still running
    // through the pipeline without a result to show for it.
    task automatic wait_until_quiet();
        @(posedge aclk);
        while (link_bytes.size() != 0 || s_tvalid || expected_drive.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [6:0] pick_key(input int n);
        case (n)
            0: return KEY_A;
            1: return KEY_B;
            2: return KEY_C;
            3: return KEY_D;
            4: return KEY_E;
            5: return KEY_F;
            6: return KEY_G;
            7: return KEY_H;
            8: return KEY_K;
            default: return KEY_L;
        endcase
    endfunction

    // Three characters for one axis. Most values are picked across the full
    // range or near the centre, where the deadband matters. A few are picked
    // at the edges of scaling and saturation. Some are arbitrary 7-bit
    // characters, and now and then an ETX falls in the middle of the payload.
    task automatic queue_axis();
        int         sel;
        int         n;
        int         i;
        logic [7:0] ch [3];
        sel = $urandom_range(99);
        if (sel < 40) begin
            n = $urandom_range(999);
        end else if (sel < 75) begin
            n = $urandom_range(150, 250);
        end else begin
            case ($urandom_range(7))
                0: n = 0;
                1: n = 100;
                2: n = 101;
                3: n = 199;
                4: n = 200;
                5: n = 256;
                6: n = 300;
                default: n = 999;
            endcase
        end
        ch[0] = 8'(48 + n / 100);
        ch[1] = 8'(48 + (n / 10) % 10);
        ch[2] = 8'(48 + n % 10);
        for (i = 0; i < 3; i++) begin
            if (sel >= 92)
                ch[i] = 8'($urandom_range(127));
            if ($urandom_range(99) < 3)
                ch[i] = ETX_BYTE;
            link_bytes.push_back(ch[i]);
        end
    endtask

    // Mostly well-formed frames with random content. The remainder is broken
    // frames and loose bytes.
    task automatic queue_random_traffic(input int target);
        int start_len;
        int sel;
        int k;
        int i;
        start_len = link_bytes.size();
        while (link_bytes.size() - start_len < target) begin
            sel = $urandom_range(99);
            link_bytes.push_back(STX_BYTE);
            if (sel < 30) begin
                if ($urandom_range(99) < 80)
                    link_bytes.push_back({1'b0, pick_key($urandom_range(9))});
                else
                    link_bytes.push_back(8'($urandom_range(127)));
                link_bytes.push_back(ETX_BYTE);
            end else if (sel < 75) begin
                queue_axis();
                queue_axis();
                link_bytes.push_back(ETX_BYTE);
            end else if (sel < 87) begin
                // A frame cut short by a high byte, or one that runs too long.
                // The byte that overruns it is often an STX, which must not
                // open a new frame.
                k = $urandom_range(6);
                for (i = 0; i < k; i++)
                    link_bytes.push_back(8'($urandom_range(127)));
                if (k < 6)
                    link_bytes.push_back(8'($urandom_range(128, 255)));
                else if ($urandom_range(1))
                    link_bytes.push_back(STX_BYTE);
                else
                    link_bytes.push_back(8'($urandom_range(255)));
            end else begin
                // The STX at the front is replaced by a loose byte of any value.
                void'(link_bytes.pop_back());
                link_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic queue_directed();
        logic [7:0] frames [$];
        // A high byte while hunting is ignored.
        frames.push_back(8'hFF);
        // A set letter and then the letter for bit five, above the bit that has no letter.
        frames.push_back(STX_BYTE); frames.push_back({1'b0, KEY_A}); frames.push_back(ETX_BYTE);
        frames.push_back(STX_BYTE); frames.push_back({1'b0, KEY_K}); frames.push_back(ETX_BYTE);
        // An early ETX as the letter. It is stored, is then an unknown letter,
        // and the frame is still reported.
        frames.push_back(STX_BYTE); frames.push_back(ETX_BYTE); frames.push_back(ETX_BYTE);
        // A high byte inside a frame.
        frames.push_back(STX_BYTE); frames.push_back(8'h80);
        // Full scale on X and zero on Y, so the right duty saturates and the left duty is two.
        frames.push_back(STX_BYTE);
        frames.push_back("9"); frames.push_back("9"); frames.push_back("9");
        frames.push_back("0"); frames.push_back("0"); frames.push_back("0");
        frames.push_back(ETX_BYTE);
        // Non-digit payload that overruns with an STX. The STX is dropped and
        // does not open a new frame.
        frames.push_back(STX_BYTE);
        frames.push_back("~"); frames.push_back("}"); frames.push_back("|");
        frames.push_back("{"); frames.push_back("z"); frames.push_back("y");
        frames.push_back(STX_BYTE);
        foreach (frames[i])
            link_bytes.push_back(frames[i]);
    endtask

    initial begin
        int db;
        deadband_setting = DEADBAND_RESET;
        frame_pos        = POS_HUNT;
        buttons          = '0;
        foreach (payload[i])
            payload[i] = '0;
        send_idle_pct = 23;
        recv_idle_pct = 85;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Deadband: the reset value first, then the two extremes, then
            // two random settings.
            if (phase != 0) begin
                wait_until_quiet();
                case (phase)
                    1: db = 0;
                    2: db = 127;
                    default: db = $urandom_range(127);
                endcase
                apb_write(DEADBAND_ADDR, 32'(db));
                deadband_setting = db;
            end
            apb_read_check(DEADBAND_ADDR, 32'(deadband_setting));
            db_history[phase] = deadband_setting;

            // A slow receiver first, then a slow sender, then full rate on
            // both sides.
            if (phase < 2) begin
                send_idle_pct = 23;
                recv_idle_pct = 85;
            end else if (phase < 4) begin
                send_idle_pct = 85;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (phase == 0) begin
                queue_directed();
                // The sender holds off here until every result of the
                // directed frames has come back.
                wait_until_quiet();
                queue_random_traffic(PHASE_ITEMS - DIRECTED_ITEMS);
            end else begin
                queue_random_traffic(PHASE_ITEMS);
            end
        end

        wait_until_quiet();
        if (expected_drive.size() != 0)
            flag_mismatch("results never delivered", 0, expected_drive.size());

        $display("Covered %0d link bytes, %0d motor and %0d button beats checked,",
                 bytes_taken, motor_beats, button_beats);
        $display("deadband settings %0d, %0d, %0d, %0d, %0d, under three idle patterns.",
                 db_history[0], db_history[1], db_history[2], db_history[3], db_history[4]);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
